[hw/rtl/nonuniform_grid_derivative_macros.svh]
// Assertion macros for the nonuniform grid derivative block.
// Included by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef NONUNIFORM_GRID_DERIVATIVE_MACROS_SVH
`define NONUNIFORM_GRID_DERIVATIVE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define NGD_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ngd check failed");
// Next-cycle implication.
`define NGD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ngd check failed");
`else
`define NGD_ASSERT_IMPLIES(label, ante, cons)
`define NGD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hw/rtl/ngd_pkg.sv]
// Shared types and constants for the nonuniform grid derivative block.
// No dependencies.
package ngd_pkg;

    localparam int XW     = 32;  // input coordinate and value width
    localparam int DIFF_W = 33;  // exact difference of two inputs
    localparam int DEN_W  = 32;  // divisor magnitude width
    localparam int QUO_W  = 48;  // capped quotient width
    localparam int NUM2_W = 50;  // numerator of the curvature division
    localparam int SUM_W  = 50;  // sum of three slopes
    localparam int OUT_W  = 32;  // derivative output width
    localparam int PIDX_W = 16;  // point index output width

    localparam logic [QUO_W-1:0] SLOPE_LIM = 48'h7FFF_FFFF_FFFF;
    localparam logic [QUO_W-1:0] D2_LIM    = 48'h0000_8000_0000;

    typedef enum logic [1:0] {
        OP_AB,
        OP_AC,
        OP_BC,
        OP_D2
    } div_op_t;

    typedef enum logic [2:0] {
        KIND_A,     // left point of the first window
        KIND_B,     // middle point
        KIND_C,     // final point
        KIND_ERR0,  // short grid, point 0 when more follow
        KIND_ERRN   // short grid, last point
    } res_kind_t;

    typedef struct packed {
        logic      capture;
        logic      div_start;
        div_op_t   div_op;
        logic      load_out;
        res_kind_t kind;
        logic      commit;
    } ngd_cmd_t;

    typedef struct packed {
        logic cur_ge2;
        logic cur_is1;
        logic cur_is2;
        logic fin;
        logic spacing_bad;
        logic div_done;
        logic out_free;
    } ngd_status_t;

endpackage

[hw/rtl/ngd_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle, with capped quotient.
// Depends on ngd_pkg and nonuniform_grid_derivative_macros.svh.
`include "nonuniform_grid_derivative_macros.svh"

module ngd_div
    import ngd_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic [NUM2_W+FRAC_BITS-1:0]             dividend,
    input  logic [$clog2(NUM2_W+FRAC_BITS+1)-1:0]   steps,
    input  logic [DEN_W-1:0]                        divisor,
    input  logic [QUO_W-1:0]                        lim,
    output logic                                    done,
    output logic [QUO_W-1:0]                        quot
);

    localparam int DIV_W = NUM2_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [QUO_W-1:0] lim_reg, lim_next;
    logic             ovf_reg, ovf_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial = {rem_reg, num_reg[DIV_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});

        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        lim_next  = lim_reg;
        ovf_next  = ovf_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;

        if (start)
        begin
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            quo_next  = '0;
            lim_next  = lim;
            ovf_next  = 1'b0;
            cnt_next  = steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            // bits pushed out of the top only ever mean saturation
            quo_next = {quo_reg[QUO_W-2:0], ge};
            ovf_next = ovf_reg | quo_reg[QUO_W-1];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        lim_reg <= lim_next;
        ovf_reg <= ovf_next;
    end

    assign done = done_reg;
    assign quot = (ovf_reg || (quo_reg > lim_reg)) ? lim_reg : quo_reg;

    `NGD_ASSERT_IMPLIES(a_start_when_free, start, !busy_reg)
    `NGD_ASSERT_IMPLIES(a_done_not_busy, done_reg, !busy_reg)
    `NGD_ASSERT_NEXT(a_last_step_done, busy_reg && (cnt_reg == CNT_W'(1)) && !start, done_reg)
    `NGD_ASSERT_IMPLIES(a_quot_capped, done_reg, quot <= lim_reg)

endmodule

[hw/rtl/ngd_dp.sv]
// Datapath: point history, operand selection, shared divider, slope registers,
// result assembly and output register. Depends on ngd_pkg and ngd_div.
module ngd_dp
    import ngd_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int INDEX_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ngd_cmd_t                 cmd,
    output ngd_status_t              status,
    input  logic signed [XW-1:0]     grid_position,
    input  logic signed [XW-1:0]     sample_value,
    input  logic                     final_point,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic [PIDX_W-1:0]        point_index,
    output logic signed [OUT_W-1:0]  first_derivative,
    output logic signed [OUT_W-1:0]  second_derivative,
    output logic                     bad_window,
    output logic                     end_of_grid
);

    localparam int DIV_W       = NUM2_W + FRAC_BITS;
    localparam int CNT_W       = $clog2(DIV_W + 1);
    localparam int SLOPE_STEPS = DIFF_W + FRAC_BITS;
    localparam int D2_STEPS    = NUM2_W + FRAC_BITS;
    localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-OUT_W:0] top;
        logic signed [OUT_W-1:0] r;
        top = v[SUM_W-1:OUT_W-1];
        if ((top == '0) || (top == '1))
            r = v[OUT_W-1:0];
        else if (v[SUM_W-1])
            r = {1'b1, {(OUT_W-1){1'b0}}};
        else
            r = {1'b0, {(OUT_W-1){1'b1}}};
        return r;
    endfunction

    logic signed [XW-1:0]     xa_reg, xb_reg, xc_reg;
    logic signed [XW-1:0]     ua_reg, ub_reg, uc_reg;
    logic                     fin_reg;
    logic [INDEX_BITS-1:0]    points_reg, points_next;
    logic signed [QUO_W-1:0]  sab_reg, sac_reg, sbc_reg;
    logic signed [OUT_W-1:0]  d2_reg;
    div_op_t                  op_reg;
    logic                     neg_reg;

    logic                     out_valid_reg, out_valid_next;
    logic [PIDX_W-1:0]        pidx_reg;
    logic signed [OUT_W-1:0]  d1_out_reg, d2_out_reg;
    logic                     bad_out_reg, end_out_reg;

    logic signed [DIFF_W-1:0] dab, dac, dbc, nab, nac, nbc;
    logic                     spacing_bad;
    logic signed [NUM2_W-1:0] d2_diff, num_s, num_abs;
    logic signed [DIFF_W-1:0] den_s, den_abs;
    logic                     neg;
    logic [DIV_W-1:0]         div_dividend;
    logic [CNT_W-1:0]         div_steps;
    logic [QUO_W-1:0]         div_lim;
    logic                     div_done;
    logic [QUO_W-1:0]         div_quot;
    logic signed [QUO_W:0]    sq;

    logic signed [SUM_W-1:0]  d1_sum;
    logic                     is_err;
    logic                     zero_out;
    logic [INDEX_BITS-1:0]    idx;
    logic                     is_end;

    // window differences, exact at 33 bits
    always_comb
    begin
        dab = DIFF_W'(xb_reg) - DIFF_W'(xa_reg);
        dac = DIFF_W'(xc_reg) - DIFF_W'(xa_reg);
        dbc = DIFF_W'(xc_reg) - DIFF_W'(xb_reg);
        nab = DIFF_W'(ub_reg) - DIFF_W'(ua_reg);
        nac = DIFF_W'(uc_reg) - DIFF_W'(ua_reg);
        nbc = DIFF_W'(uc_reg) - DIFF_W'(ub_reg);
        spacing_bad = (dab == '0) || (dac == '0) || (dbc == '0);
    end

    // divider operands: magnitudes plus a sign for the quotient
    always_comb
    begin
        d2_diff = NUM2_W'(sac_reg) - NUM2_W'(sbc_reg);
        case (cmd.div_op)
            OP_AB:
            begin
                num_s = NUM2_W'(nab);
                den_s = dab;
            end
            OP_AC:
            begin
                num_s = NUM2_W'(nac);
                den_s = dac;
            end
            OP_BC:
            begin
                num_s = NUM2_W'(nbc);
                den_s = dbc;
            end
            OP_D2:
            begin
                num_s = d2_diff <<< 1;
                den_s = dab;
            end
            default:
            begin
                num_s = '0;
                den_s = dab;
            end
        endcase
        // curvature divides by the negated left spacing
        neg     = num_s[NUM2_W-1] ^ den_s[DIFF_W-1] ^ (cmd.div_op == OP_D2);
        num_abs = num_s[NUM2_W-1] ? -num_s : num_s;
        den_abs = den_s[DIFF_W-1] ? -den_s : den_s;
        if (cmd.div_op == OP_D2)
        begin
            div_dividend = DIV_W'(num_abs) << (DIV_W - NUM2_W);
            div_steps    = CNT_W'(D2_STEPS);
            div_lim      = D2_LIM;
        end
        else
        begin
            div_dividend = DIV_W'(num_abs[DIFF_W-1:0]) << (DIV_W - DIFF_W);
            div_steps    = CNT_W'(SLOPE_STEPS);
            div_lim      = SLOPE_LIM;
        end
    end

    ngd_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .steps    (div_steps),
        .divisor  (den_abs[DEN_W-1:0]),
        .lim      (div_lim),
        .done     (div_done),
        .quot     (div_quot)
    );

    assign sq = neg_reg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});

    // result assembly for the selected kind
    always_comb
    begin
        case (cmd.kind)
            KIND_A:  d1_sum = SUM_W'(sab_reg) + SUM_W'(sac_reg) - SUM_W'(sbc_reg);
            KIND_B:  d1_sum = SUM_W'(sab_reg) - SUM_W'(sac_reg) + SUM_W'(sbc_reg);
            KIND_C:  d1_sum = SUM_W'(sac_reg) + SUM_W'(sbc_reg) - SUM_W'(sab_reg);
            default: d1_sum = '0;
        endcase
        case (cmd.kind)
            KIND_B:  idx = points_reg - 1'b1;
            KIND_C:  idx = points_reg;
            KIND_ERRN: idx = points_reg;
            default: idx = '0;
        endcase
        is_err   = (cmd.kind == KIND_ERR0) || (cmd.kind == KIND_ERRN);
        zero_out = is_err || spacing_bad;
        is_end   = (cmd.kind == KIND_C) || (cmd.kind == KIND_ERRN);
    end

    always_comb
    begin
        points_next = points_reg;
        if (cmd.commit)
        begin
            if (fin_reg)
                points_next = '0;
            else if (points_reg != INDEX_MAX)
                points_next = points_reg + 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            points_reg    <= points_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            xc_reg  <= grid_position;
            uc_reg  <= sample_value;
            fin_reg <= final_point;
        end
        if (cmd.commit)
        begin
            xa_reg <= xb_reg;
            xb_reg <= xc_reg;
            ua_reg <= ub_reg;
            ub_reg <= uc_reg;
        end
        if (cmd.div_start)
        begin
            op_reg  <= cmd.div_op;
            neg_reg <= neg;
        end
        if (div_done)
        begin
            case (op_reg)
                OP_AB:   sab_reg <= sq[QUO_W-1:0];
                OP_AC:   sac_reg <= sq[QUO_W-1:0];
                OP_BC:   sbc_reg <= sq[QUO_W-1:0];
                OP_D2:   d2_reg  <= sat_out(SUM_W'(sq));
                default: d2_reg  <= d2_reg;
            endcase
        end
        if (cmd.load_out)
        begin
            pidx_reg    <= PIDX_W'(idx);
            d1_out_reg  <= zero_out ? '0 : sat_out(d1_sum);
            d2_out_reg  <= zero_out ? '0 : d2_reg;
            bad_out_reg <= zero_out;
            end_out_reg <= is_end;
        end
    end

    always_comb
    begin
        status.cur_ge2     = (points_reg >= INDEX_BITS'(2));
        status.cur_is1     = (points_reg == INDEX_BITS'(1));
        status.cur_is2     = (points_reg == INDEX_BITS'(2));
        status.fin         = fin_reg;
        status.spacing_bad = spacing_bad;
        status.div_done    = div_done;
        status.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid         = out_valid_reg;
    assign point_index       = pidx_reg;
    assign first_derivative  = d1_out_reg;
    assign second_derivative = d2_out_reg;
    assign bad_window        = bad_out_reg;
    assign end_of_grid       = end_out_reg;

endmodule

[hw/rtl/ngd_ctrl.sv]
// Controller: sequences capture, the four divisions, result emission and commit.
// Depends on ngd_pkg.
module ngd_ctrl
    import ngd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ngd_status_t status,
    output ngd_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT
    } state_t;

    state_t    state_reg, state_next;
    div_op_t   op_reg, op_next;
    res_kind_t kind_reg, kind_next;
    res_kind_t first_kind;
    logic      has_next;
    res_kind_t after_kind;

    always_comb
    begin
        if (status.cur_ge2)
            first_kind = status.cur_is2 ? KIND_A : KIND_B;
        else
            first_kind = status.cur_is1 ? KIND_ERR0 : KIND_ERRN;

        case (kind_reg)
            KIND_A:
            begin
                has_next   = 1'b1;
                after_kind = status.fin ? KIND_C : KIND_B;
            end
            KIND_B:
            begin
                has_next   = status.fin;
                after_kind = KIND_C;
            end
            KIND_ERR0:
            begin
                has_next   = 1'b1;
                after_kind = KIND_ERRN;
            end
            default:
            begin
                has_next   = 1'b0;
                after_kind = KIND_C;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        kind_next  = kind_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.div_op = op_reg;
        cmd.kind   = kind_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = S_PLAN;
            end
            S_PLAN:
            begin
                if (status.cur_ge2 && !status.spacing_bad)
                begin
                    op_next    = OP_AB;
                    state_next = S_DIV_GO;
                end
                else if (status.cur_ge2 || status.fin)
                begin
                    kind_next  = first_kind;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    case (op_reg)
                        OP_AB:   op_next = OP_AC;
                        OP_AC:   op_next = OP_BC;
                        OP_BC:   op_next = OP_D2;
                        default: op_next = OP_D2;
                    endcase
                    if (op_reg == OP_D2)
                    begin
                        kind_next  = first_kind;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (has_next)
                    begin
                        kind_next = after_kind;
                    end
                    else
                    begin
                        cmd.commit = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_AB;
            kind_reg  <= KIND_A;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

[hw/rtl/nonuniform_grid_derivative.sv]
// Top level of the nonuniform grid derivative block: controller plus datapath.
// Depends on ngd_pkg, ngd_ctrl, ngd_dp (and ngd_div below it).
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------------
//   in       | in_valid / in_ready  | grid_position, sample_value, final_point
//   out      | out_valid / out_ready| point_index, first_derivative,
//            |                      | second_derivative, bad_window, end_of_grid
//
// One item at a time. A full window runs four divisions on the shared radix-2 divider, three
// of 33+FRAC_BITS steps and one of 50+FRAC_BITS, and gives one result or two.
// The first two points of a grid only enter the history; a zero spacing or a short grid
// skips the divider. Reset clears the point count and the output valid.
// A stalled output holds the result register; the next item is still taken, its results wait.
module nonuniform_grid_derivative
    import ngd_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int INDEX_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [XW-1:0]     grid_position,
    input  logic signed [XW-1:0]     sample_value,
    input  logic                     final_point,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [PIDX_W-1:0]        point_index,
    output logic signed [OUT_W-1:0]  first_derivative,
    output logic signed [OUT_W-1:0]  second_derivative,
    output logic                     bad_window,
    output logic                     end_of_grid
);

    // commands down to the datapath, status back to the controller
    ngd_cmd_t    cmd;
    ngd_status_t status;

    // sequence capture, divisions, emission and history commit
    ngd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // hold the window, run the divider, assemble and register the results
    ngd_dp #(
        .FRAC_BITS  (FRAC_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .grid_position     (grid_position),
        .sample_value      (sample_value),
        .final_point       (final_point),
        .out_ready         (out_ready),
        .out_valid         (out_valid),
        .point_index       (point_index),
        .first_derivative  (first_derivative),
        .second_derivative (second_derivative),
        .bad_window        (bad_window),
        .end_of_grid       (end_of_grid)
    );

endmodule

[dv/nonuniform_grid_derivative_tb.sv]
// Self-checking testbench for nonuniform_grid_derivative: streams grids of points through
// the block and checks every result against typed rows or a built-in three-point parabola fit predictor.
// Depends on ngd_pkg and the nonuniform_grid_derivative RTL; reads no files.
module nonuniform_grid_derivative_tb
    import ngd_pkg::*;
();

    localparam int FRAC           = 16;
    localparam int IDX_BITS       = 16;
    localparam int INDEX_MAX      = (1 << IDX_BITS) - 1;
    localparam int WATCHDOG_LIMIT = 20000;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES   = 400;    // well past one full window
    localparam int PHASE_POINTS   = 240;

    localparam logic signed [XW-1:0] XMIN = 32'sh8000_0000;
    localparam logic signed [XW-1:0] XMAX = 32'sh7FFF_FFFF;
    localparam logic signed [XW-1:0] ONE  = 32'sh0001_0000;

    typedef struct packed {
        logic [PIDX_W-1:0]       point_idx;
        logic signed [OUT_W-1:0] d1;
        logic signed [OUT_W-1:0] d2;
        logic                    bad;
        logic                    last;
    } grid_result_t;

    // One directed row; typed_cnt < 0 means the predictor supplies the expected results.
    typedef struct {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] u;
        logic                 fin;
        int                   typed_cnt;
        grid_result_t         t0;
        grid_result_t         t1;
    } stim_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic signed [XW-1:0]    grid_position = '0;
    logic signed [XW-1:0]    sample_value = '0;
    logic                    final_point = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [PIDX_W-1:0]       point_index;
    logic signed [OUT_W-1:0] first_derivative;
    logic signed [OUT_W-1:0] second_derivative;
    logic                    bad_window;
    logic                    end_of_grid;

    // Predictor state: two previous points (index 1 newest) and the point count.
    longint       hist_pos [0:1];
    longint       hist_val [0:1];
    int unsigned  grid_count;

    grid_result_t fit_out[$];         // results of the last predicted point
    grid_result_t pending_derivs[$];  // expected results, oldest first
    stim_row_t    directed_rows[$];
    grid_result_t want;

    int send_idle = 31;  // percent of cycles the sender holds back
    int recv_idle = 71;  // percent of cycles the receiver stalls
    int mismatches = 0;
    int fed_points = 0;
    int quiet_cycles = 0;

    nonuniform_grid_derivative #(
        .FRAC_BITS  (FRAC),
        .INDEX_BITS (IDX_BITS)
    ) uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .grid_position     (grid_position),
        .sample_value      (sample_value),
        .final_point       (final_point),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .point_index       (point_index),
        .first_derivative  (first_derivative),
        .second_derivative (second_derivative),
        .bad_window        (bad_window),
        .end_of_grid       (end_of_grid)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic grid_result_t mk_res(input longint idx, input longint d1,
                                            input longint d2, input logic bad,
                                            input logic last);
        grid_result_t r;
        r.point_idx = idx[PIDX_W-1:0];
        r.d1        = d1[OUT_W-1:0];
        r.d2        = d2[OUT_W-1:0];
        r.bad       = bad;
        r.last      = last;
        return r;
    endfunction

    // (num << FRAC) / den truncated toward zero, bit by bit, magnitude pinned at cap.
    function automatic longint quot_sat(input longint num, input longint den,
                                        input longint unsigned cap);
        bit                neg;
        longint unsigned   n, d, q, r;
        int                k;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = n / d;
        r = n % d;
        if (q > cap)
            q = cap;
        for (k = 0; k < FRAC; k++)
        begin
            if (q >= cap)
            begin
                q = cap;
                break;
            end
            r = r << 1;
            q = q << 1;
            if (r >= d)
            begin
                r = r - d;
                q = q | 64'd1;
            end
            if (q > cap)
                q = cap;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clip_out(input longint v);
        if (v > 64'sh7FFF_FFFF)
            return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000)
            return -64'sh8000_0000;
        return v;
    endfunction

    // Fit the parabola through the stored pair and the new point; fill fit_out.
    task automatic fit_window(input logic signed [XW-1:0] x, input logic signed [XW-1:0] u,
                              input logic fin);
        longint      xc, uc, xa, xb, ua, ub, dab, dac, dbc;
        longint      sab, sac, sbc, d1a, d1b, d1c, d2;
        int unsigned cur;
        logic        bad;
        int          k;
        xc = x;
        uc = u;
        cur = grid_count;
        fit_out.delete();
        if (cur >= 2)
        begin
            xa = hist_pos[0];
            xb = hist_pos[1];
            ua = hist_val[0];
            ub = hist_val[1];
            dab = xb - xa;
            dac = xc - xa;
            dbc = xc - xb;
            d1a = 0;
            d1b = 0;
            d1c = 0;
            d2 = 0;
            bad = (dab == 0) || (dac == 0) || (dbc == 0);
            if (!bad)
            begin
                sab = quot_sat(ub - ua, dab, SLOPE_LIM);
                sac = quot_sat(uc - ua, dac, SLOPE_LIM);
                sbc = quot_sat(uc - ub, dbc, SLOPE_LIM);
                d1a = clip_out(sab + sac - sbc);
                d1b = clip_out(sab - sac + sbc);
                d1c = clip_out(sac + sbc - sab);
                d2  = clip_out(quot_sat(2 * (sac - sbc), -dab, D2_LIM));
            end
            if (cur == 2)
                fit_out.push_back(mk_res(0, d1a, d2, bad, 1'b0));
            // A three-point grid skips the middle point.
            if (!(cur == 2 && fin))
                fit_out.push_back(mk_res(cur - 1, d1b, d2, bad, 1'b0));
            if (fin)
                fit_out.push_back(mk_res(cur, d1c, d2, bad, 1'b1));
        end
        else if (fin)
        begin
            // Short grid: one error result per point received.
            for (k = 0; k <= cur; k++)
                fit_out.push_back(mk_res(k, 0, 0, 1'b1, k == cur));
        end
        hist_pos[0] = hist_pos[1];
        hist_val[0] = hist_val[1];
        hist_pos[1] = xc;
        hist_val[1] = uc;
        if (fin)
            grid_count = 0;
        else if (cur < INDEX_MAX)
            grid_count = cur + 1;
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Present one point and hold it until the block takes it. Valid drops only when
    // the sender idles, so a back-to-back item never sees valid lowered and raised.
    task automatic push_point(input logic signed [XW-1:0] x, input logic signed [XW-1:0] u,
                              input logic fin);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        grid_position <= x;
        sample_value  <= u;
        final_point   <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic feed_point(input logic signed [XW-1:0] x, input logic signed [XW-1:0] u,
                              input logic fin);
        push_point(x, u, fin);
        fit_window(x, u, fin);
        while (fit_out.size() != 0)
            pending_derivs.push_back(fit_out.pop_front());
        fed_points++;
    endtask

    function automatic void add_row(input logic signed [XW-1:0] x,
                                    input logic signed [XW-1:0] u, input logic fin,
                                    input int typed_cnt, input grid_result_t t0,
                                    input grid_result_t t1);
        stim_row_t r;
        r.x = x;
        r.u = u;
        r.fin = fin;
        r.typed_cnt = typed_cnt;
        r.t0 = t0;
        r.t1 = t1;
        directed_rows.push_back(r);
    endfunction

    // One well-formed grid with random length, spacing and content. Short grids,
    // repeated positions and full-range noise grids are mixed in.
    task automatic random_grid();
        int                   len, style, k;
        logic signed [XW-1:0] x, u, step;
        len = ($urandom_range(9) < 2) ? $urandom_range(1, 3) : $urandom_range(4, 14);
        style = $urandom_range(3);
        x = $urandom_range(0, 32'h00FF_FFFF) - 32'sh0080_0000;
        for (k = 0; k < len; k++)
        begin
            case (style)
                0: step = $urandom_range(1, 32'h0004_0000);
                1: step = 32'sd0 - $urandom_range(1, 32'h0004_0000);
                3: step = ($urandom_range(7) == 0) ? 32'sd0 : $urandom_range(1, 32'h0000_1000);
                default: step = 32'sd0;
            endcase
            if (style == 2)
                x = $urandom;
            else if (k > 0)
                x = x + step;
            if (style == 2 || $urandom_range(3) == 0)
                u = $urandom;
            else
                u = $urandom_range(0, 32'h001F_FFFF) - 32'sh0010_0000;
            feed_point(x, u, k == len - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    task automatic log_mismatch(input string what, input longint got, input longint exp_val);
        mismatches++;
        $display("ngd tb error: %s got %0d expected %0d", what, got, exp_val);
    endtask

    // Check every accepted result against the oldest expectation, field by field.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_derivs.size() == 0)
                log_mismatch("unexpected result at point", point_index, -1);
            else
            begin
                want = pending_derivs.pop_front();
                if (point_index !== want.point_idx)
                    log_mismatch("point_index", point_index, want.point_idx);
                if (first_derivative !== want.d1)
                    log_mismatch("first_derivative", first_derivative, want.d1);
                if (second_derivative !== want.d2)
                    log_mismatch("second_derivative", second_derivative, want.d2);
                if (bad_window !== want.bad)
                    log_mismatch("bad_window", bad_window, want.bad);
                if (end_of_grid !== want.last)
                    log_mismatch("end_of_grid", end_of_grid, want.last);
            end
        end
    end

    // Abort when neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("nonuniform_grid_derivative: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        int                   i, start;
        stim_row_t            r;

        hist_pos[0] = 0;
        hist_pos[1] = 0;
        hist_val[0] = 0;
        hist_val[1] = 0;
        grid_count = 0;

        // Single-point grid: one error result that also closes the grid.
        add_row(0, 0, 1'b1, 1, mk_res(0, 0, 0, 1'b1, 1'b1), '0);
        // Two-point grid at the coordinate extremes: two error results.
        add_row(XMIN, XMAX, 1'b0, 0, '0, '0);
        add_row(XMAX, XMIN, 1'b1, 2, mk_res(0, 0, 0, 1'b1, 1'b0),
                mk_res(1, 0, 0, 1'b1, 1'b1));
        // Three-point grid on u = x^2: results for points 0 and 2 only.
        add_row(0, 0, 1'b0, -1, '0, '0);
        add_row(ONE, ONE, 1'b0, -1, '0, '0);
        add_row(2 * ONE, 4 * ONE, 1'b1, -1, '0, '0);
        // Three-point grid with a repeated position: both results flagged.
        add_row(5, 7, 1'b0, 0, '0, '0);
        add_row(5, 9, 1'b0, 0, '0, '0);
        add_row(10, 3, 1'b1, 2, mk_res(0, 0, 0, 1'b1, 1'b0),
                mk_res(2, 0, 0, 1'b1, 1'b1));
        // Extreme positions and values: slopes and outputs saturate.
        add_row(XMIN, XMIN, 1'b0, -1, '0, '0);
        add_row(XMIN + 1, XMAX, 1'b0, -1, '0, '0);
        add_row(XMIN + 2, XMIN, 1'b0, -1, '0, '0);
        add_row(XMAX - 1, XMAX, 1'b0, -1, '0, '0);
        add_row(XMAX, XMIN, 1'b1, -1, '0, '0);
        // Outer points coincide in the first window only.
        add_row(0, ONE, 1'b0, -1, '0, '0);
        add_row(100, -ONE, 1'b0, -1, '0, '0);
        add_row(0, ONE, 1'b0, -1, '0, '0);
        add_row(50, XMAX, 1'b1, -1, '0, '0);
        // Repeated position in the closing window of a longer grid.
        add_row(0, 0, 1'b0, -1, '0, '0);
        add_row(ONE, ONE, 1'b0, -1, '0, '0);
        add_row(2 * ONE, ONE, 1'b0, -1, '0, '0);
        add_row(2 * ONE, 0, 1'b1, -1, '0, '0);
        // Descending positions, small values.
        add_row(3 * ONE, 7, 1'b0, -1, '0, '0);
        add_row(ONE, -5, 1'b0, -1, '0, '0);
        add_row(-ONE, 2, 1'b1, -1, '0, '0);

        // Hold reset, then release it.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table; typed rows override the predicted results.
        for (i = 0; i < directed_rows.size(); i++)
        begin
            r = directed_rows[i];
            if (r.typed_cnt < 0)
                feed_point(r.x, r.u, r.fin);
            else
            begin
                push_point(r.x, r.u, r.fin);
                fit_window(r.x, r.u, r.fin);
                if (r.typed_cnt > 0)
                    pending_derivs.push_back(r.t0);
                if (r.typed_cnt > 1)
                    pending_derivs.push_back(r.t1);
                fed_points++;
            end
        end

        // Random grids: sender idles 31%, receiver 71%; then swapped; then no idling.
        start = fed_points;
        while (fed_points - start < PHASE_POINTS)
            random_grid();
        send_idle = 71;
        recv_idle = 31;
        start = fed_points;
        while (fed_points - start < PHASE_POINTS)
            random_grid();
        send_idle = 0;
        recv_idle = 0;
        start = fed_points;
        while (fed_points - start < PHASE_POINTS)
            random_grid();
        in_valid <= 1'b0;

        // Drain: wait for every expected result, then watch for strays.
        while (pending_derivs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("nonuniform_grid_derivative: match");
        else
            $display("nonuniform_grid_derivative: mismatch");
        $finish;
    end

endmodule
